// ===== src/hrsp_pkg.sv =====
// hrsp_pkg: shared types, codes and header-name tables for the request parser
// no dependencies; imported by every module of the block
package hrsp_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS    = 17;

    localparam logic [15:0] MAX_HDR_RESET = 16'd8192;

    // parser phases
    localparam logic [3:0] PH_METHOD  = 4'd0;
    localparam logic [3:0] PH_URI     = 4'd1;
    localparam logic [3:0] PH_VERSION = 4'd2;
    localparam logic [3:0] PH_HEADER  = 4'd3;
    localparam logic [3:0] PH_BODYLEN = 4'd4;
    localparam logic [3:0] PH_CHUNK   = 4'd5;
    localparam logic [3:0] PH_DONE    = 4'd6;
    localparam logic [3:0] PH_ERROR   = 4'd7;

    // chunk decoder sub states
    localparam logic [2:0] CS_SIZE    = 3'd0;
    localparam logic [2:0] CS_SIZE_LF = 3'd1;
    localparam logic [2:0] CS_DATA    = 3'd2;
    localparam logic [2:0] CS_DATA_CR = 3'd3;
    localparam logic [2:0] CS_DATA_LF = 3'd4;
    localparam logic [2:0] CS_TR_CR   = 3'd5;
    localparam logic [2:0] CS_TR_LF   = 3'd6;

    // field tags
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_METHOD  = 3'd1;
    localparam logic [2:0] KIND_URI     = 3'd2;
    localparam logic [2:0] KIND_VERSION = 3'd3;
    localparam logic [2:0] KIND_BODY    = 3'd4;

    // header kinds
    localparam logic [1:0] HK_NONE = 2'd0;
    localparam logic [1:0] HK_CL   = 2'd1;
    localparam logic [1:0] HK_TE   = 2'd2;

    // header line scan stages
    localparam logic [1:0] LS_NAME  = 2'd0;
    localparam logic [1:0] LS_COLON = 2'd1;
    localparam logic [1:0] LS_VALUE = 2'd2;
    localparam logic [1:0] LS_SKIP  = 2'd3;

    // value scan stages
    localparam logic [1:0] VS_LEAD = 2'd0;
    localparam logic [1:0] VS_ACT  = 2'd1;
    localparam logic [1:0] VS_STOP = 2'd2;

    localparam logic [4:0] CL_LEN = 5'd14;
    localparam logic [4:0] TE_LEN = 5'd17;
    localparam logic [2:0] CH_LEN = 3'd7;

    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_SP    = 8'h20;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_VT    = 8'h0B;
    localparam logic [7:0] C_FF    = 8'h0C;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_COLON = 8'h3A;

    // one classified input byte as it travels through the queue
    typedef struct packed {
        logic       restart;
        logic [7:0] data;
        logic       is_cr;
        logic       is_lf;
        logic       is_sp;
        logic       is_ws;
        logic       is_vtff;
        logic       is_dig;
        logic       is_hex;
        logic [3:0] nib;
    } t_cls;

    function automatic logic [7:0] cl_char(input logic [4:0] idx);
        logic [7:0] c;
        unique case (idx)
            5'd0:  c = "C";
            5'd1:  c = "o";
            5'd2:  c = "n";
            5'd3:  c = "t";
            5'd4:  c = "e";
            5'd5:  c = "n";
            5'd6:  c = "t";
            5'd7:  c = "-";
            5'd8:  c = "L";
            5'd9:  c = "e";
            5'd10: c = "n";
            5'd11: c = "g";
            5'd12: c = "t";
            5'd13: c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] te_char(input logic [4:0] idx);
        logic [7:0] c;
        unique case (idx)
            5'd0:  c = "T";
            5'd1:  c = "r";
            5'd2:  c = "a";
            5'd3:  c = "n";
            5'd4:  c = "s";
            5'd5:  c = "f";
            5'd6:  c = "e";
            5'd7:  c = "r";
            5'd8:  c = "-";
            5'd9:  c = "E";
            5'd10: c = "n";
            5'd11: c = "c";
            5'd12: c = "o";
            5'd13: c = "d";
            5'd14: c = "i";
            5'd15: c = "n";
            5'd16: c = "g";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ch_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = "c";
            3'd1: c = "h";
            3'd2: c = "u";
            3'd3: c = "n";
            3'd4: c = "k";
            3'd5: c = "e";
            3'd6: c = "d";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== src/hrsp_front.sv =====
// hrsp_front: input side, accepts bytes and classifies them for the back end
// depends on hrsp_pkg; feeds hrsp_fifo
module hrsp_front
    import hrsp_pkg::*;
(
    input  logic       i_in_valid,
    input  logic       i_restart,
    input  logic [7:0] i_in_byte,
    input  logic       i_q_full,
    output logic       o_in_stall,
    output logic       o_push,
    output t_cls       o_cls
);

    // stall while the queue has no room
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid & ~i_q_full;

    // character classes used by the parser
    always_comb begin
        o_cls.restart = i_restart;
        o_cls.data    = i_in_byte;
        o_cls.is_cr   = (i_in_byte == C_CR);
        o_cls.is_lf   = (i_in_byte == C_LF);
        o_cls.is_sp   = (i_in_byte == C_SP);
        o_cls.is_ws   = (i_in_byte == C_SP) || (i_in_byte == C_TAB) ||
                        (i_in_byte == C_CR) || (i_in_byte == C_LF);
        o_cls.is_vtff = (i_in_byte == C_VT) || (i_in_byte == C_FF);
        o_cls.is_dig  = (i_in_byte >= "0") && (i_in_byte <= "9");
        o_cls.is_hex  = 1'b1;
        o_cls.nib     = 4'd0;
        priority if (i_in_byte >= "0" && i_in_byte <= "9") begin
            o_cls.nib = 4'(i_in_byte - "0");
        end else if (i_in_byte >= "a" && i_in_byte <= "f") begin
            o_cls.nib = 4'(i_in_byte - "a" + 8'd10);
        end else if (i_in_byte >= "A" && i_in_byte <= "F") begin
            o_cls.nib = 4'(i_in_byte - "A" + 8'd10);
        end else begin
            o_cls.is_hex = 1'b0;
        end
    end

endmodule

// ===== src/hrsp_fifo.sv =====
// hrsp_fifo: short queue of classified bytes between front and back
// depends on hrsp_pkg
module hrsp_fifo
    import hrsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cls o_data
);

    t_cls                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== src/hrsp_back.sv =====
// hrsp_back: request parser state machine and registered result stage
// depends on hrsp_pkg; reads from hrsp_fifo
module hrsp_back
    import hrsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_max_hdr,
    input  logic        i_q_empty,
    input  t_cls        i_q_data,
    output logic        o_pop,
    input  logic        i_res_stall,
    output logic        o_res_valid,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_kind,
    output logic        o_field_end,
    output logic        o_done_res,
    output logic        o_error
);

    logic [3:0]             r_phase, n_phase;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;
    logic [1:0]             r_crlf, n_crlf;
    logic [4:0]             r_nmi, n_nmi;
    logic [1:0]             r_hk, n_hk;
    logic [2:0]             r_vmi, n_vmi;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic                   r_chk, n_chk;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic [2:0]             r_cs, n_cs;
    logic [1:0]             r_ls, n_ls;
    logic [1:0]             r_vs, n_vs;

    logic                   r_res_valid;
    logic                   r_ov, n_ov;
    logic [7:0]             r_ob, n_ob;
    logic [2:0]             r_kind, n_kind;
    logic                   r_fe, n_fe;
    logic                   r_done, r_err;

    logic [2:0]             m;
    logic                   bad;
    logic                   over;
    logic                   lend;
    logic                   hend;
    logic                   nmatch;
    logic [LENGTH_BITS+3:0] dec;
    t_cls                   d;

    assign d     = i_q_data;
    assign o_pop = ~i_q_empty & (~r_res_valid | ~i_res_stall);

    // decimal accumulate: len*10 + digit
    assign dec = ({4'b0, r_len} << 3) + ({4'b0, r_len} << 1) +
                 {(LENGTH_BITS)'(0), d.nib};
    assign nmatch = (r_hk == HK_CL) ? (r_nmi < CL_LEN && d.data == cl_char(r_nmi))
                                    : (r_nmi < TE_LEN && d.data == te_char(r_nmi));

    // next state for one byte
    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_crlf = r_crlf; n_nmi = r_nmi;
        n_hk = r_hk; n_vmi = r_vmi; n_len = r_len; n_chk = r_chk;
        n_rem = r_rem; n_cs = r_cs; n_ls = r_ls; n_vs = r_vs;
        n_ov = 1'b0; n_ob = 8'd0; n_kind = KIND_NONE; n_fe = 1'b0;
        m = 3'd0; bad = 1'b0; lend = 1'b0; hend = 1'b0; over = 1'b0;
        if (d.restart) begin
            n_phase = PH_METHOD; n_cnt = '0; n_crlf = 2'd0;
            n_ls = LS_NAME; n_nmi = '0; n_hk = HK_NONE; n_vmi = '0; n_vs = VS_LEAD;
            n_len = '0; n_chk = 1'b0; n_rem = '0; n_cs = CS_SIZE;
        end else if (r_phase <= PH_VERSION) begin
            // request line
            n_cnt = r_cnt + 1'b1;
            if (r_crlf == 2'd1) begin
                if (d.is_lf && r_phase == PH_VERSION) m = 3'd2;
                else bad = 1'b1;
            end else if (d.is_cr) begin
                m = 3'd1;
            end
            over = ({1'b0, n_cnt} > ({2'b0, i_max_hdr} + {15'b0, m}));
            priority if (bad || over) begin
                n_phase = PH_ERROR;
            end else if (m == 3'd2) begin
                n_kind = KIND_VERSION; n_fe = 1'b1; n_phase = PH_HEADER; n_crlf = 2'd2;
                n_ls = LS_NAME; n_nmi = '0; n_hk = HK_NONE; n_vmi = '0; n_vs = VS_LEAD;
            end else if (m == 3'd1) begin
                n_crlf = 2'd1;
            end else if (d.is_sp && r_phase != PH_VERSION) begin
                n_kind = r_phase[2:0] + 3'd1; n_fe = 1'b1; n_phase = r_phase + 4'd1;
            end else begin
                n_ov = 1'b1; n_ob = d.data; n_kind = r_phase[2:0] + 3'd1;
            end
        end else if (r_phase == PH_HEADER) begin
            // header lines
            n_crlf = 2'd0;
            if (d.is_cr) n_crlf = (r_crlf == 2'd2) ? 2'd3 : 2'd1;
            else if (d.is_lf && r_crlf == 2'd1) begin n_crlf = 2'd2; lend = 1'b1; end
            else if (d.is_lf && r_crlf == 2'd3) hend = 1'b1;
            m = hend ? 3'd4 : {1'b0, n_crlf};
            n_cnt = r_cnt + 1'b1;
            over = ({1'b0, n_cnt} > ({2'b0, i_max_hdr} + {15'b0, m}));
            priority if (over) begin
                n_phase = PH_ERROR;
            end else if (lend) begin
                if (r_ls == LS_VALUE && r_hk == HK_TE && r_vs != VS_STOP && r_vmi == CH_LEN)
                    n_chk = 1'b1;
                n_ls = LS_NAME; n_nmi = '0; n_hk = HK_NONE; n_vmi = '0; n_vs = VS_LEAD;
            end else if (hend) begin
                priority if (r_chk) begin
                    n_phase = PH_CHUNK; n_cs = CS_SIZE; n_rem = '0;
                end else if (r_len == '0) begin
                    n_phase = PH_DONE; n_kind = KIND_BODY; n_fe = 1'b1;
                end else begin
                    n_phase = PH_BODYLEN;
                end
            end else begin
                unique case (r_ls)
                    LS_NAME: begin
                        if (r_nmi == '0) begin
                            priority if (d.is_ws) begin
                            end else if (d.data == "C") begin
                                n_hk = HK_CL; n_nmi = 5'd1;
                            end else if (d.data == "T") begin
                                n_hk = HK_TE; n_nmi = 5'd1;
                            end else begin
                                n_ls = LS_SKIP;
                            end
                        end else if (nmatch) begin
                            n_nmi = r_nmi + 5'd1;
                            if (n_nmi == ((r_hk == HK_CL) ? CL_LEN : TE_LEN)) n_ls = LS_COLON;
                        end else begin
                            n_ls = LS_SKIP;
                        end
                    end
                    LS_COLON: begin
                        priority if (d.is_ws) begin
                        end else if (d.data == C_COLON) begin
                            n_ls = LS_VALUE; n_vs = VS_LEAD; n_vmi = '0;
                            if (r_hk == HK_CL) n_len = '0;
                        end else begin
                            n_ls = LS_SKIP;
                        end
                    end
                    LS_VALUE: begin
                        if (r_hk == HK_CL) begin
                            // content length digits, saturating
                            priority if (r_vs == VS_LEAD && (d.is_ws || d.is_vtff)) begin
                            end else if (r_vs == VS_LEAD && d.data == C_PLUS) begin
                                n_vs = VS_ACT;
                            end else if (r_vs != VS_STOP && d.is_dig) begin
                                n_vs = VS_ACT;
                                n_len = (dec[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? '1
                                      : dec[LENGTH_BITS-1:0];
                            end else begin
                                n_vs = VS_STOP;
                            end
                        end else begin
                            // transfer encoding value match
                            priority if (r_vs == VS_STOP) begin
                            end else if (r_vmi >= CH_LEN) begin
                                if (!d.is_ws) n_vs = VS_STOP;
                            end else if (r_vmi == '0 && d.is_ws) begin
                            end else if (d.data == ch_char(r_vmi)) begin
                                n_vmi = r_vmi + 3'd1;
                            end else begin
                                n_vs = VS_STOP;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end else if (r_phase == PH_BODYLEN) begin
            n_ov = 1'b1; n_ob = d.data; n_kind = KIND_BODY;
            n_len = r_len - 1'b1;
            if (n_len == '0) begin
                n_fe = 1'b1; n_phase = PH_DONE;
            end
        end else if (r_phase == PH_CHUNK) begin
            // chunked framing
            unique case (r_cs)
                CS_SIZE: begin
                    priority if (d.is_cr) n_cs = CS_SIZE_LF;
                    else if (!d.is_hex) n_phase = PH_ERROR;
                    else if (r_rem[LENGTH_BITS-1:LENGTH_BITS-4] != 4'd0) n_rem = '1;
                    else n_rem = {r_rem[LENGTH_BITS-5:0], d.nib};
                end
                CS_SIZE_LF: begin
                    if (!d.is_lf) n_phase = PH_ERROR;
                    else n_cs = (r_rem == '0) ? CS_TR_CR : CS_DATA;
                end
                CS_DATA: begin
                    n_ov = 1'b1; n_ob = d.data; n_kind = KIND_BODY;
                    n_rem = r_rem - 1'b1;
                    if (n_rem == '0) n_cs = CS_DATA_CR;
                end
                CS_DATA_CR: begin
                    if (d.is_cr) n_cs = CS_DATA_LF; else n_phase = PH_ERROR;
                end
                CS_DATA_LF: begin
                    if (d.is_lf) n_cs = CS_SIZE; else n_phase = PH_ERROR;
                end
                CS_TR_CR: begin
                    if (d.is_cr) n_cs = CS_TR_LF; else n_phase = PH_ERROR;
                end
                CS_TR_LF: begin
                    if (d.is_lf) begin
                        n_phase = PH_DONE; n_kind = KIND_BODY; n_fe = 1'b1;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                default: n_phase = PH_ERROR;
            endcase
        end
        // error step shows only the flag
        if (n_phase == PH_ERROR) begin
            n_ov = 1'b0; n_ob = 8'd0; n_kind = KIND_NONE; n_fe = 1'b0;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_METHOD; r_cnt <= '0; r_crlf <= 2'd0; r_nmi <= '0;
            r_hk <= HK_NONE; r_vmi <= '0; r_len <= '0; r_chk <= 1'b0;
            r_rem <= '0; r_cs <= CS_SIZE; r_ls <= LS_NAME; r_vs <= VS_LEAD;
        end else if (o_pop) begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_crlf <= n_crlf; r_nmi <= n_nmi;
            r_hk <= n_hk; r_vmi <= n_vmi; r_len <= n_len; r_chk <= n_chk;
            r_rem <= n_rem; r_cs <= n_cs; r_ls <= n_ls; r_vs <= n_vs;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (o_pop) begin
            r_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ov   <= n_ov;
            r_ob   <= n_ob;
            r_kind <= n_kind;
            r_fe   <= n_fe;
            r_done <= (n_phase == PH_DONE);
            r_err  <= (n_phase == PH_ERROR);
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_out_valid = r_ov;
    assign o_out_byte  = r_ob;
    assign o_kind      = r_kind;
    assign o_field_end = r_fe;
    assign o_done_res  = r_done;
    assign o_error     = r_err;

`ifndef SYNTHESIS
    a_done_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> !(r_done && r_err))
        else $error("done and error both set");
    a_valid_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_ov) |-> (r_kind != KIND_NONE))
        else $error("emitted byte without a field tag");
    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_err) |-> (!r_ov && !r_fe && r_kind == KIND_NONE))
        else $error("error result carries payload");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && i_res_stall) |=> (r_res_valid && $stable(r_ob) && $stable(r_kind)))
        else $error("result changed while stalled");
`endif

endmodule

// ===== src/http_request_stream_parser.sv =====
// http_request_stream_parser: top level, register port and front/queue/back wiring
// depends on hrsp_pkg, hrsp_front, hrsp_fifo, hrsp_back
//
// Parses an HTTP/1.1 request one byte per transaction and returns one result per
// byte: request line fields tagged method/uri/version, body bytes by content
// length or chunked decoding, and sticky done and error flags. Sustained rate is
// one byte per clock while the result side does not stall. A byte passes through
// the four-entry queue, then the parser stage writes its result register; a result
// stall holds bytes in the queue. The per-byte parser update is the single stage
// that sets this rate. max_header_bytes sits at address 0 (aliased at 0 to 3); the
// user writes it only while the block is idle, which the block does not enforce.
module http_request_stream_parser
    import hrsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_restart,
    input  logic [7:0]  i_in_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_kind,
    output logic        o_field_end,
    output logic        o_done_res,
    output logic        o_error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_max_hdr;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    t_cls        cls_in;
    t_cls        cls_out;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, r_max_hdr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_hdr <= MAX_HDR_RESET;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_max_hdr <= pwdata[15:0];
        end
    end

    hrsp_front u_front (
        .i_in_valid (i_in_valid),
        .i_restart  (i_restart),
        .i_in_byte  (i_in_byte),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_cls      (cls_in)
    );

    hrsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (cls_out)
    );

    hrsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_hdr   (r_max_hdr),
        .i_q_empty   (q_empty),
        .i_q_data    (cls_out),
        .o_pop       (pop),
        .i_res_stall (i_res_stall),
        .o_res_valid (o_res_valid),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_kind      (o_kind),
        .o_field_end (o_field_end),
        .o_done_res  (o_done_res),
        .o_error     (o_error)
    );

endmodule
